[sv/mphm_pkg.sv]
`timescale 1ns / 1ps
package mphm_pkg;
  localparam int unsigned CapacityDef = 1024;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned SizeW = 11;
  localparam int unsigned FuncW = 2;
  localparam int unsigned StatW = 2;
  localparam logic [SizeW-1:0] BaseRst = 11'd16;

  localparam logic [FuncW-1:0] FuncSet = 2'd0;
  localparam logic [FuncW-1:0] FuncGet = 2'd1;
  localparam logic [FuncW-1:0] FuncDel = 2'd2;

  localparam logic [StatW-1:0] StatOk = 2'd0;
  localparam logic [StatW-1:0] StatFull = 2'd1;
  localparam logic [StatW-1:0] StatKeyZero = 2'd2;
endpackage

[sv/mphm_mod.sv]
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, remainder out.
module mphm_mod #(
  parameter int unsigned DW = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mphm_pkg::KeyW-1:0] num_i,
  input  logic [DW-1:0]             den_i,
  output logic                      done_o,
  output logic [DW-1:0]             rem_o
);
  import mphm_pkg::*;
  localparam int unsigned CntW = $clog2(KeyW + 1);

  logic [KeyW-1:0] num_q, num_d;
  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DW:0]     trial, diff;

  assign trial = {rem_q[DW-1:0], num_q[KeyW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0;
      cnt_d = CntW'(KeyW); busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      rem_d = diff[DW] ? trial : diff;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[DW-1:0];
endmodule

[sv/modulo_probe_hash_map.sv]
`timescale 1ns / 1ps
// Key-value table with modulo probing. One operation is accepted when start
// is high and busy low; its result appears for one cycle with done and cannot
// be stalled. Each probe costs a 32-step radix-2 remainder plus control and a
// table read, so an operation takes longer the more divisors it walks. A set
// that grows the table up to CAPACITY walks up to about 2*CAPACITY/base_size
// divisors. A set with key zero, a get or delete with key zero, or an unused
// code goes straight from idle to the result without a probe. A base_size
// write is taken only while idle with start low. After reset and after each
// base_size write, a clearing pass zeroes every key memory entry before start
// is taken.
module modulo_probe_hash_map #(
  parameter int unsigned CAPACITY = mphm_pkg::CapacityDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [mphm_pkg::FuncW-1:0]  func_i,
  input  logic [mphm_pkg::KeyW-1:0]   key_i,
  input  logic [mphm_pkg::ValW-1:0]   value_i,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mphm_pkg::SizeW-1:0]  cfg_data,
  output logic                        done,
  output logic [mphm_pkg::StatW-1:0]  status_o,
  output logic                        hit_o,
  output logic [mphm_pkg::ValW-1:0]   value_out_o,
  output logic [mphm_pkg::SizeW-1:0]  size_now_o
);
  import mphm_pkg::*;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned DW = $clog2(CAPACITY) + 2;
  localparam logic [DW-1:0] BaseInit = (BaseRst > CAPACITY) ? DW'(CAPACITY) : DW'(BaseRst);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_WAIT, S_RD, S_CHK, S_NEXT, S_OUT
  } state_e;

  state_e           st_q;
  logic [AW:0]      clr_q;
  logic [FuncW-1:0] fn_q;
  logic [KeyW-1:0]  key_q;
  logic [ValW-1:0]  val_q;
  logic [DW-1:0]    base_q, size_q, d_q, s_q;
  logic             grow_q;
  logic [StatW-1:0] stat_q;
  logic             hit_q, done_q;
  logic [ValW-1:0]  vout_q;
  logic [DW-1:0]    ix_q;
  logic [KeyW-1:0]  rk_q;
  logic [ValW-1:0]  rv_q;
  logic [KeyW-1:0]  kmem [CAPACITY];
  logic [ValW-1:0]  vmem [CAPACITY];
  logic             kwe, vwe;
  logic [AW-1:0]    waddr;
  logic [KeyW-1:0]  kwd;
  logic [ValW-1:0]  vwd;
  logic             div_start, div_done;
  logic [DW-1:0]    div_rem;
  logic [DW-1:0]    cfg_b;

  mphm_mod #(.DW(DW)) u_mod (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(key_q),
    .den_i(d_q), .done_o(div_done), .rem_o(div_rem)
  );

  always_comb begin
    cfg_b = DW'(cfg_data);
    if (cfg_data == '0) cfg_b = DW'(1);
    if (DW'(cfg_data) > DW'(CAPACITY)) cfg_b = DW'(CAPACITY);
  end

  assign busy      = (st_q != S_IDLE);
  assign cfg_ready = (st_q == S_IDLE) && !start;
  assign div_start = (st_q == S_DIV);

  always_comb begin
    kwe = 1'b0; vwe = 1'b0; waddr = ix_q[AW-1:0]; kwd = key_q; vwd = val_q;
    if (st_q == S_CLR) begin
      kwe = 1'b1; waddr = clr_q[AW-1:0]; kwd = '0;
    end else if (st_q == S_CHK) begin
      if (fn_q == FuncSet && (rk_q == '0 || (grow_q && ix_q >= size_q))) begin
        kwe = 1'b1; vwe = 1'b1;
      end else if (fn_q == FuncDel && rk_q == key_q) begin
        kwe = 1'b1; kwd = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (kwe) kmem[waddr] <= kwd;
    if (vwe) vmem[waddr] <= vwd;
    rk_q <= kmem[ix_q[AW-1:0]];
    rv_q <= vmem[ix_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; base_q <= BaseInit; size_q <= BaseInit;
      done_q <= 1'b0; stat_q <= StatOk; hit_q <= 1'b0; vout_q <= '0;
      fn_q <= FuncSet; key_q <= '0; val_q <= '0; d_q <= '0; s_q <= '0;
      grow_q <= 1'b0; ix_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(CAPACITY - 1)) st_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            fn_q <= func_i; key_q <= key_i; val_q <= value_i;
            stat_q <= StatOk; hit_q <= 1'b0; vout_q <= '0;
            d_q <= base_q; grow_q <= 1'b0;
            if (func_i == FuncSet && key_i == '0) begin
              stat_q <= StatKeyZero; st_q <= S_OUT;
            end else if (key_i == '0 || func_i > FuncDel) begin
              st_q <= S_OUT;
            end else begin
              st_q <= S_DIV;
            end
          end else if (cfg_valid) begin
            base_q <= cfg_b; size_q <= cfg_b; clr_q <= '0; st_q <= S_CLR;
          end
        end
        S_DIV:  st_q <= S_WAIT;
        S_WAIT: if (div_done) begin
          ix_q <= div_rem; st_q <= S_RD;
        end
        S_RD:   st_q <= S_CHK;
        S_CHK: begin
          st_q <= S_NEXT;
          if (fn_q == FuncSet && (rk_q == '0 || (grow_q && ix_q >= size_q))) begin
            if (grow_q) size_q <= s_q;
            st_q <= S_OUT;
          end else if (fn_q == FuncGet && rk_q == key_q) begin
            hit_q <= 1'b1; vout_q <= rv_q; st_q <= S_OUT;
          end
        end
        S_NEXT: begin
          st_q <= S_DIV;
          if (!grow_q) begin
            if (d_q + base_q <= size_q) begin
              d_q <= d_q + base_q;
            end else if (fn_q != FuncSet) begin
              st_q <= S_OUT;
            end else if (size_q <= DW'(CAPACITY / 2)) begin
              grow_q <= 1'b1; s_q <= size_q << 1; d_q <= size_q + base_q;
              if (size_q + base_q > (size_q << 1)) st_q <= S_NEXT;
            end else begin
              stat_q <= StatFull; st_q <= S_OUT;
            end
          end else begin
            if (d_q + base_q <= s_q) begin
              d_q <= d_q + base_q;
            end else if (s_q <= DW'(CAPACITY / 2)) begin
              s_q <= s_q << 1; d_q <= size_q + base_q;
              if (size_q + base_q > (s_q << 1)) st_q <= S_NEXT;
            end else begin
              stat_q <= StatFull; st_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          done_q <= 1'b1; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign done        = done_q;
  assign status_o    = stat_q;
  assign hit_o       = hit_q;
  assign value_out_o = vout_q;
  assign size_now_o  = SizeW'(size_q);
endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  import mphm_pkg::*;

  localparam int unsigned Cap = CapacityDef;
  localparam int unsigned StallLimit = 250000;

  typedef struct {
    bit                is_cfg;
    bit                drain;
    bit                quiet;
    logic [FuncW-1:0]  func;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   val;
    logic [SizeW-1:0]  cfg;
  } op_t;

  typedef struct {
    logic [StatW-1:0]  status;
    logic              hit;
    logic [ValW-1:0]   val;
    logic [SizeW-1:0]  size;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FuncW-1:0] func_i = '0;
  logic [KeyW-1:0] key_i = '0;
  logic [ValW-1:0] value_i = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SizeW-1:0] cfg_data = '0;
  logic done;
  logic [StatW-1:0] status_o;
  logic hit_o;
  logic [ValW-1:0] value_out_o;
  logic [SizeW-1:0] size_now_o;

  modulo_probe_hash_map dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .key_i, .value_i,
    .cfg_valid, .cfg_ready, .cfg_data, .done,
    .status_o, .hit_o, .value_out_o, .size_now_o
  );

  always #5 clk_i = ~clk_i;

  op_t    pending[$];
  reply_t replies_due[$];
  op_t    in_flight;

  logic [KeyW-1:0] key_mem[Cap];
  logic [ValW-1:0] val_mem[Cap];
  int unsigned tbl_size, tbl_base;

  int errors = 0, n_ops = 0, n_replies = 0, n_cfg = 0;
  int n_full = 0, n_kzero = 0, n_hit = 0, n_grow = 0;
  int gap = 0, settle = 0, stall = 0;
  logic [KeyW-1:0] key_pool[$];

  function automatic void clear_table(int unsigned b);
    tbl_base = (b == 0) ? 1 : ((b > Cap) ? Cap : b);
    tbl_size = tbl_base;
    for (int i = 0; i < Cap; i++) begin
      key_mem[i] = '0;
      val_mem[i] = '0;
    end
  endfunction

  function automatic logic [StatW-1:0] table_insert(logic [KeyW-1:0] k, logic [ValW-1:0] v);
    int unsigned ix;
    if (k == 0) return StatKeyZero;
    for (int unsigned d = tbl_base; d <= tbl_size; d += tbl_base) begin
      ix = k % d;
      if (key_mem[ix] == 0) begin
        key_mem[ix] = k;
        val_mem[ix] = v;
        return StatOk;
      end
    end
    for (int unsigned s = tbl_size * 2; s <= Cap; s *= 2) begin
      for (int unsigned d = tbl_size + tbl_base; d <= s; d += tbl_base) begin
        ix = k % d;
        if (ix >= tbl_size || key_mem[ix] == 0) begin
          key_mem[ix] = k;
          val_mem[ix] = v;
          tbl_size = s;
          n_grow++;
          return StatOk;
        end
      end
    end
    return StatFull;
  endfunction

  function automatic reply_t table_op(op_t o);
    reply_t r;
    int unsigned ix;
    r = '{StatOk, 1'b0, '0, '0};
    if (o.func == FuncSet) begin
      r.status = table_insert(o.key, o.val);
    end else if (o.func == FuncGet && o.key != 0) begin
      for (int unsigned d = tbl_base; d <= tbl_size; d += tbl_base) begin
        ix = o.key % d;
        if (key_mem[ix] == o.key) begin
          r.hit = 1'b1;
          r.val = val_mem[ix];
          break;
        end
      end
    end else if (o.func == FuncDel && o.key != 0) begin
      for (int unsigned d = tbl_base; d <= tbl_size; d += tbl_base) begin
        ix = o.key % d;
        if (key_mem[ix] == o.key) begin
          key_mem[ix] = '0;
          val_mem[ix] = '0;
        end
      end
    end
    r.size = tbl_size[SizeW-1:0];
    return r;
  endfunction

  task automatic add_op(logic [FuncW-1:0] f, logic [KeyW-1:0] k, logic [ValW-1:0] v,
                        bit drain = 0, bit quiet = 0);
    op_t o;
    o = '{0, drain, quiet, f, k, v, '0};
    pending.push_back(o);
  endtask

  task automatic add_cfg(logic [SizeW-1:0] b);
    op_t o;
    o = '{1, 0, 0, FuncSet, '0, '0, b};
    pending.push_back(o);
  endtask

  task automatic random_phase(logic [SizeW-1:0] b, int count, bit quiet);
    logic [KeyW-1:0] k;
    int sel;
    add_cfg(b);
    key_pool.delete();
    for (int i = 0; i < 24; i++)
      key_pool.push_back((i % 3 == 0) ? $urandom() : $urandom_range(1, 5000));
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 19);
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 23)] : $urandom();
      if (sel < 8) add_op(FuncSet, k, $urandom(), 0, quiet);
      else if (sel < 13) add_op(FuncGet, k, $urandom(), 0, quiet);
      else if (sel < 17) add_op(FuncDel, k, $urandom(), 0, quiet);
      else if (sel == 17) add_op(2'd3, k, $urandom(), 0, quiet);
      else add_op(FuncW'($urandom_range(0, 2)), '0, $urandom(), 0, quiet);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    op_t o;
    reply_t r;
    logic nxt_start, nxt_cfg;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg = cfg_valid;
      if (start && !busy) begin
        r = table_op(in_flight);
        replies_due.push_back(r);
        n_ops++;
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        clear_table(cfg_data);
        n_cfg++;
        nxt_cfg = 1'b0;
      end
      settle = (replies_due.size() == 0 && !busy) ? settle + 1 : 0;
      if (!nxt_start && !nxt_cfg) begin
        if (gap > 0) begin
          gap--;
        end else if (pending.size() > 0) begin
          o = pending[0];
          if (o.is_cfg) begin
            if (settle >= 8) begin
              void'(pending.pop_front());
              cfg_data <= o.cfg;
              nxt_cfg = 1'b1;
            end
          end else if (!o.drain || replies_due.size() == 0) begin
            void'(pending.pop_front());
            in_flight = o;
            func_i <= o.func;
            key_i <= o.key;
            value_i <= o.val;
            nxt_start = 1'b1;
            if (!o.quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
          end
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && done) begin
      n_replies++;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: status=%0d hit=%0b val=%h size=%0d",
                   status_o, hit_o, value_out_o, size_now_o);
      end else begin
        e = replies_due.pop_front();
        if (e.status == StatFull) n_full++;
        if (e.status == StatKeyZero) n_kzero++;
        if (e.hit) n_hit++;
        if (status_o !== e.status || hit_o !== e.hit || value_out_o !== e.val ||
            size_now_o !== e.size) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch on result %0d: exp status=%0d hit=%0b val=%h size=%0d,",
                      " got status=%0d hit=%0b val=%h size=%0d"},
                     n_replies, e.status, e.hit, e.val, e.size,
                     status_o, hit_o, value_out_o, size_now_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_ni) stall <= 0;
    else stall <= stall + 1;
    if (stall >= StallLimit) begin
      $display("modulo_probe_hash_map verification failed");
      $finish;
    end
  end

  initial begin
    clear_table(BaseRst);
    // directed, default base 16
    add_op(FuncSet, '0, 32'h1234);
    add_op(FuncSet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(FuncGet, 32'hFFFF_FFFF, '0);
    add_op(FuncSet, 32'd16, 32'h0);
    add_op(FuncSet, 32'd32, 32'hA5A5_5A5A);
    add_op(FuncGet, 32'd32, '0);
    add_op(FuncSet, 32'd16, 32'h5555_AAAA);
    add_op(FuncDel, 32'd16, '0);
    add_op(FuncGet, 32'd16, '0);
    add_op(FuncGet, '0, '0);
    add_op(FuncDel, '0, '0);
    add_op(2'd3, 32'd32, 32'h1);
    add_op(FuncGet, 32'h8000_0001, '0, 1);
    // base equal to capacity: one slot per key, so a colliding set is full
    add_cfg(11'd1024);
    add_op(FuncSet, 32'd5, 32'd1);
    add_op(FuncSet, 32'd1029, 32'd2);
    add_op(FuncGet, 32'd1029, '0);
    add_op(FuncGet, 32'd5, '0);
    // zero base saturates to one
    add_cfg(11'd0);
    add_op(FuncSet, 32'd7, 32'd70);
    add_op(FuncSet, 32'd8, 32'd80);
    add_op(FuncSet, 32'd9, 32'd90);
    add_op(FuncGet, 32'd8, '0);
    add_op(FuncDel, 32'd7, '0);
    // oversize base saturates to capacity
    add_cfg(11'd2047);
    add_op(FuncSet, 32'd2048, 32'd3);
    add_op(FuncSet, 32'd4096, 32'd4);

    random_phase(11'd64, 70, 0);
    random_phase(11'd16, 60, 0);
    random_phase(11'd128, 70, 0);
    random_phase(11'd1024, 40, 0);
    random_phase(11'd33, 60, 0);
    random_phase(11'd512, 60, 0);
    random_phase(11'd2, 12, 0);
    random_phase(11'd100, 70, 0);
    random_phase(11'd256, 60, 1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending.size() > 0 || start || cfg_valid || replies_due.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (replies_due.size() > 0) errors++;
    $display("ran %0d operations over %0d base sizes, %0d results checked", n_ops, n_cfg,
             n_replies);
    $display("seen: %0d hits, %0d full, %0d key zero, %0d table growths", n_hit, n_full,
             n_kzero, n_grow);
    if (errors == 0) begin
      $display("modulo_probe_hash_map verification clean");
    end else begin
      $display("modulo_probe_hash_map verification failed");
    end
    $finish;
  end
endmodule
